>>> hdl/triangle_longest_edge_split_core_macros.svh
// assertion helpers for the edge split core
`ifndef TRIANGLE_LONGEST_EDGE_SPLIT_CORE_MACROS_SVH
`define TRIANGLE_LONGEST_EDGE_SPLIT_CORE_MACROS_SVH

// same-cycle implication
`define TLES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tles_pkg.sv
package tles_pkg;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
        logic [15:0]        attr_tag;
        logic               last_of_batch;
    } t_in;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic signed [23:0] out_z;
        logic signed [23:0] out_u;
        logic signed [23:0] out_v;
        logic [15:0]        out_tag;
        logic [1:0]         corner;
        logic               was_split;
        logic               run_last;
        logic               batch_end;
    } t_out;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic signed [23:0] u;
        logic signed [23:0] v;
    } t_vtx;

    typedef enum logic [1:0] {
        EDGE_BC = 2'd0,
        EDGE_AC = 2'd1,
        EDGE_AB = 2'd2
    } t_edge;

    typedef enum logic [1:0] {
        VSEL_A = 2'd0,
        VSEL_B = 2'd1,
        VSEL_C = 2'd2,
        VSEL_M = 2'd3
    } t_vsel;

    localparam int unsigned STEP_W = 5;
    localparam int unsigned IDX_W  = 3;

    // multiplier schedule, one product per step
    localparam logic [STEP_W-1:0] ST_CX    = 5'd0;
    localparam logic [STEP_W-1:0] ST_CY    = 5'd2;
    localparam logic [STEP_W-1:0] ST_CZ    = 5'd4;
    localparam logic [STEP_W-1:0] ST_SQX   = 5'd6;
    localparam logic [STEP_W-1:0] ST_SQY   = 5'd9;
    localparam logic [STEP_W-1:0] ST_SQZ   = 5'd12;
    localparam logic [STEP_W-1:0] ST_LIM   = 5'd15;
    localparam logic [STEP_W-1:0] ST_LA    = 5'd18;
    localparam logic [STEP_W-1:0] ST_LB    = 5'd21;
    localparam logic [STEP_W-1:0] ST_LC    = 5'd24;
    localparam logic [STEP_W-1:0] ST_COUNT = 5'd27;

    localparam logic [IDX_W-1:0] IDX_PLAIN_LAST = 3'd2;
    localparam logic [IDX_W-1:0] IDX_SPLIT_LAST = 3'd5;

    localparam logic [1:0] CORNER_C = 2'd2;

    typedef struct packed {
        logic              cap_a;
        logic              cap_b;
        logic              cap_c;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              decide;
        logic              mid;
        logic              load_out;
        logic [IDX_W-1:0]  out_idx;
    } t_cmd;

    typedef struct packed {
        logic split;
    } t_sts;

    // which vertex goes out at each position of the run
    function automatic t_vsel emit_sel(logic split, t_edge edge_sel, logic [IDX_W-1:0] k);
        t_vsel s;
        s = VSEL_A;
        if (!split) begin
            case (k)
                3'd0:    s = VSEL_A;
                3'd1:    s = VSEL_B;
                default: s = VSEL_C;
            endcase
        end else begin
            case (edge_sel)
                EDGE_BC: begin
                    case (k)
                        3'd0, 3'd3: s = VSEL_A;
                        3'd1:       s = VSEL_B;
                        3'd2, 3'd4: s = VSEL_M;
                        default:    s = VSEL_C;
                    endcase
                end
                EDGE_AC: begin
                    case (k)
                        3'd0:       s = VSEL_A;
                        3'd1, 3'd4: s = VSEL_B;
                        3'd2, 3'd3: s = VSEL_M;
                        default:    s = VSEL_C;
                    endcase
                end
                default: begin
                    case (k)
                        3'd0:       s = VSEL_A;
                        3'd4:       s = VSEL_B;
                        3'd1, 3'd3: s = VSEL_M;
                        default:    s = VSEL_C;
                    endcase
                end
            endcase
        end
        return s;
    endfunction

endpackage

>>> hdl/tles_ctrl.sv
module tles_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  tles_pkg::t_sts i_sts,
    output tles_pkg::t_cmd o_cmd
);
    import tles_pkg::*;

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_CALC    = 5'b00010,
        S_DECIDE  = 5'b00100,
        S_MID     = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_cnt, n_cnt;
    logic [STEP_W-1:0] r_step, n_step;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer, slot_free;

    assign o_in_ready  = (r_state == S_COLLECT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step    = r_step;
        o_cmd.out_idx = r_k;
        unique case (r_state)
            S_COLLECT: begin
                if (in_xfer) begin
                    o_cmd.cap_a = (r_cnt == 2'd0);
                    o_cmd.cap_b = (r_cnt == 2'd1);
                    o_cmd.cap_c = (r_cnt == 2'd2);
                    if (r_cnt == 2'd2) begin
                        n_cnt   = 2'd0;
                        n_step  = '0;
                        n_state = S_CALC;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            S_CALC: begin
                o_cmd.issue = (r_step != ST_COUNT);
                if (r_step == ST_COUNT) begin
                    n_state = S_DECIDE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_MID;
            end
            S_MID: begin
                o_cmd.mid = 1'b1;
                n_k       = '0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_k            = r_k + 3'd1;
                    if (r_k == (i_sts.split ? IDX_SPLIT_LAST : IDX_PLAIN_LAST)) begin
                        n_state = S_COLLECT;
                    end
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_cnt       <= '0;
            r_step      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/tles_dp.sv
module tles_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tles_pkg::t_in  i_in,
    input  logic           i_cfg_valid,
    input  logic [47:0]    i_cfg_data,
    input  tles_pkg::t_cmd i_cmd,
    output tles_pkg::t_sts o_sts,
    output tles_pkg::t_out o_out
);
    import tles_pkg::*;

    t_vtx               r_a, r_b, r_c, r_m;
    logic [15:0]        r_tag;
    logic               r_bend;
    logic [47:0]        r_limit;
    logic signed [24:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_dx, r_dy, r_dz;
    logic signed [50:0] r_cx, r_cy, r_cz;
    logic signed [105:0] r_acc;
    logic [51:0]        r_la, r_lb, r_lc;
    logic signed [53:0] r_prod;
    logic               r_wb_vld;
    logic [STEP_W-1:0]  r_wb_step;
    logic               r_split;
    t_edge              r_edge;
    t_out               r_out;

    logic signed [26:0]  op_a, op_b;
    logic [48:0]         lim2;
    logic signed [105:0] p_ext, acc_term;
    logic [51:0]         p_u;
    t_vtx                mp, mq, sel_v;
    t_vsel               vsel;

    function automatic logic signed [26:0] ext25(logic signed [24:0] d);
        return {{2{d[24]}}, d};
    endfunction

    function automatic logic signed [26:0] c_hi(logic signed [50:0] c);
        return {{2{c[50]}}, c[50:26]};
    endfunction

    function automatic logic signed [26:0] c_lo(logic signed [50:0] c);
        return {1'b0, c[25:0]};
    endfunction

    function automatic logic signed [23:0] half(logic signed [23:0] p, logic signed [23:0] q);
        logic signed [24:0] s;
        s = {p[23], p} + {q[23], q};
        return s[24:1];
    endfunction

    assign lim2 = {r_limit, 1'b0};

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.step)
            ST_CX:          begin op_a = ext25(r_ay); op_b = ext25(r_bz); end
            ST_CX + 5'd1:   begin op_a = ext25(r_az); op_b = ext25(r_by); end
            ST_CY:          begin op_a = ext25(r_az); op_b = ext25(r_bx); end
            ST_CY + 5'd1:   begin op_a = ext25(r_ax); op_b = ext25(r_bz); end
            ST_CZ:          begin op_a = ext25(r_ax); op_b = ext25(r_by); end
            ST_CZ + 5'd1:   begin op_a = ext25(r_ay); op_b = ext25(r_bx); end
            ST_SQX:         begin op_a = c_hi(r_cx); op_b = c_hi(r_cx); end
            ST_SQX + 5'd1:  begin op_a = c_hi(r_cx); op_b = c_lo(r_cx); end
            ST_SQX + 5'd2:  begin op_a = c_lo(r_cx); op_b = c_lo(r_cx); end
            ST_SQY:         begin op_a = c_hi(r_cy); op_b = c_hi(r_cy); end
            ST_SQY + 5'd1:  begin op_a = c_hi(r_cy); op_b = c_lo(r_cy); end
            ST_SQY + 5'd2:  begin op_a = c_lo(r_cy); op_b = c_lo(r_cy); end
            ST_SQZ:         begin op_a = c_hi(r_cz); op_b = c_hi(r_cz); end
            ST_SQZ + 5'd1:  begin op_a = c_hi(r_cz); op_b = c_lo(r_cz); end
            ST_SQZ + 5'd2:  begin op_a = c_lo(r_cz); op_b = c_lo(r_cz); end
            ST_LIM: begin
                op_a = {4'b0, lim2[48:26]};
                op_b = {4'b0, lim2[48:26]};
            end
            ST_LIM + 5'd1: begin
                op_a = {4'b0, lim2[48:26]};
                op_b = {1'b0, lim2[25:0]};
            end
            ST_LIM + 5'd2: begin
                op_a = {1'b0, lim2[25:0]};
                op_b = {1'b0, lim2[25:0]};
            end
            ST_LA:          begin op_a = ext25(r_ax); op_b = ext25(r_ax); end
            ST_LA + 5'd1:   begin op_a = ext25(r_ay); op_b = ext25(r_ay); end
            ST_LA + 5'd2:   begin op_a = ext25(r_az); op_b = ext25(r_az); end
            ST_LB:          begin op_a = ext25(r_bx); op_b = ext25(r_bx); end
            ST_LB + 5'd1:   begin op_a = ext25(r_by); op_b = ext25(r_by); end
            ST_LB + 5'd2:   begin op_a = ext25(r_bz); op_b = ext25(r_bz); end
            ST_LC:          begin op_a = ext25(r_dx); op_b = ext25(r_dx); end
            ST_LC + 5'd1:   begin op_a = ext25(r_dy); op_b = ext25(r_dy); end
            ST_LC + 5'd2:   begin op_a = ext25(r_dz); op_b = ext25(r_dz); end
            default:        begin op_a = '0; op_b = '0; end
        endcase
    end

    assign p_ext = {{52{r_prod[53]}}, r_prod};
    assign p_u   = r_prod[51:0];

    // weight of the partial product: high*high, cross, low*low
    always_comb begin
        case (r_wb_step)
            ST_SQX, ST_SQY, ST_SQZ, ST_LIM:                             acc_term = p_ext <<< 52;
            ST_SQX + 5'd1, ST_SQY + 5'd1, ST_SQZ + 5'd1, ST_LIM + 5'd1: acc_term = p_ext <<< 27;
            default:                                                    acc_term = p_ext;
        endcase
    end

    always_comb begin
        case (r_edge)
            EDGE_BC: begin mp = r_b; mq = r_c; end
            EDGE_AC: begin mp = r_a; mq = r_c; end
            default: begin mp = r_a; mq = r_b; end
        endcase
    end

    assign vsel = emit_sel(r_split, r_edge, i_cmd.out_idx);

    always_comb begin
        case (vsel)
            VSEL_A:  sel_v = r_a;
            VSEL_B:  sel_v = r_b;
            VSEL_C:  sel_v = r_c;
            default: sel_v = r_m;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= '1;
            r_wb_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            r_wb_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_step <= i_cmd.step;
        r_prod    <= op_a * op_b;

        if (i_cmd.cap_a) begin
            r_a   <= '{i_in.pos_x, i_in.pos_y, i_in.pos_z, i_in.tex_u, i_in.tex_v};
            r_tag <= i_in.attr_tag;
        end
        if (i_cmd.cap_b) begin
            r_b <= '{i_in.pos_x, i_in.pos_y, i_in.pos_z, i_in.tex_u, i_in.tex_v};
        end
        if (i_cmd.cap_c) begin
            r_c    <= '{i_in.pos_x, i_in.pos_y, i_in.pos_z, i_in.tex_u, i_in.tex_v};
            r_bend <= i_in.last_of_batch;
            r_ax   <= 25'(r_b.x) - 25'(i_in.pos_x);
            r_ay   <= 25'(r_b.y) - 25'(i_in.pos_y);
            r_az   <= 25'(r_b.z) - 25'(i_in.pos_z);
            r_bx   <= 25'(r_a.x) - 25'(i_in.pos_x);
            r_by   <= 25'(r_a.y) - 25'(i_in.pos_y);
            r_bz   <= 25'(r_a.z) - 25'(i_in.pos_z);
            r_dx   <= 25'(r_a.x) - 25'(r_b.x);
            r_dy   <= 25'(r_a.y) - 25'(r_b.y);
            r_dz   <= 25'(r_a.z) - 25'(r_b.z);
            r_acc  <= '0;
        end

        if (r_wb_vld) begin
            case (r_wb_step)
                ST_CX:         r_cx <= r_prod[50:0];
                ST_CX + 5'd1:  r_cx <= r_cx - r_prod[50:0];
                ST_CY:         r_cy <= r_prod[50:0];
                ST_CY + 5'd1:  r_cy <= r_cy - r_prod[50:0];
                ST_CZ:         r_cz <= r_prod[50:0];
                ST_CZ + 5'd1:  r_cz <= r_cz - r_prod[50:0];
                ST_LIM, ST_LIM + 5'd1, ST_LIM + 5'd2:
                               r_acc <= r_acc - acc_term;
                ST_LA:         r_la <= p_u;
                ST_LA + 5'd1, ST_LA + 5'd2:
                               r_la <= r_la + p_u;
                ST_LB:         r_lb <= p_u;
                ST_LB + 5'd1, ST_LB + 5'd2:
                               r_lb <= r_lb + p_u;
                ST_LC:         r_lc <= p_u;
                ST_LC + 5'd1, ST_LC + 5'd2:
                               r_lc <= r_lc + p_u;
                default:       r_acc <= r_acc + acc_term;
            endcase
        end

        if (i_cmd.decide) begin
            // four times (area squared minus limit squared), split only when strictly above
            r_split <= (r_acc > 106'sd0);
            if (r_la > r_lb) begin
                r_edge <= (r_la > r_lc) ? EDGE_BC : EDGE_AB;
            end else begin
                r_edge <= (r_lb > r_lc) ? EDGE_AC : EDGE_AB;
            end
        end

        if (i_cmd.mid) begin
            r_m <= '{half(mp.x, mq.x), half(mp.y, mq.y), half(mp.z, mq.z),
                     half(mp.u, mq.u), half(mp.v, mq.v)};
        end

        if (i_cmd.load_out) begin
            r_out.out_x     <= sel_v.x;
            r_out.out_y     <= sel_v.y;
            r_out.out_z     <= sel_v.z;
            r_out.out_u     <= sel_v.u;
            r_out.out_v     <= sel_v.v;
            r_out.out_tag   <= r_tag;
            r_out.corner    <= (i_cmd.out_idx >= 3'd3) ? 2'(i_cmd.out_idx - 3'd3)
                                                       : 2'(i_cmd.out_idx);
            r_out.was_split <= r_split;
            r_out.run_last  <= (i_cmd.out_idx == (r_split ? IDX_SPLIT_LAST : IDX_PLAIN_LAST));
            r_out.batch_end <= r_bend &&
                               (i_cmd.out_idx == (r_split ? IDX_SPLIT_LAST : IDX_PLAIN_LAST));
        end
    end

    assign o_sts.split = r_split;
    assign o_out       = r_out;

endmodule

>>> hdl/triangle_longest_edge_split_core.sv
// Longest-edge split of a vertex stream, one pass. Every three accepted vertices form
// triangle A, B, C. If its area is above the area_limit register, the longest edge is
// cut at its midpoint (floor rounding) and six vertices leave as two triangles;
// otherwise A, B, C leave unchanged. The three vertices of a triangle can be taken in
// consecutive cycles; after the third, the block runs a schedule of 27 products
// through one shared 27x27 multiplier, then decide and midpoint steps, and then hands
// out 3 or 6 vertices, one per cycle while the sink keeps up. No new vertex is taken
// until the last one of a triangle has been loaded into the output register. The next
// triangle's vertices are taken while the final result still waits in the output
// register. area_limit may only be written while no triangle is in flight; its write
// port never stalls.
`include "triangle_longest_edge_split_core_macros.svh"

module triangle_longest_edge_split_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tles_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tles_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [47:0]    i_cfg_data
);
    import tles_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register write always completes in one transfer
    assign o_cfg_ready = 1'b1;

    // sequencer: vertex collection, multiply schedule, emit count
    tles_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // vertex store, shared multiplier, area test, edge pick, output register
    tles_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

    // the end-of-batch flag only rides on the final vertex of a run
    `TLES_ASSERT_NOW(a_bend_on_last, o_out_valid && o_out.batch_end, o_out.run_last, "batch_end without run_last")
    // every run ends on a C corner
    `TLES_ASSERT_NOW(a_last_is_c, o_out_valid && o_out.run_last, o_out.corner == CORNER_C, "run ends off corner C")
    // inside a run the next vertex is loaded in the same cycle as the transfer
    `TLES_ASSERT_NEXT(a_run_gapless, o_out_valid && i_out_ready && !o_out.run_last, o_out_valid, "gap inside a run")

endmodule
